[design/lmss_pkg.sv]
// Shared types and constants for the LED matrix scroll scanner.
// No dependencies; every other design file refers to this package by scoped names.
package lmss_pkg;

   localparam int MODULES            = 10;
   localparam int COLUMNS_PER_MODULE = 5;
   localparam int BUFFER_DEPTH       = 56;

   localparam int ADDR_W  = $clog2(BUFFER_DEPTH);
   localparam int POS_W   = 8;              // holds any column position plus one step
   localparam int CMP_W   = POS_W + 1;      // room to compare against the depth itself
   localparam int MOD_W   = $clog2(MODULES + 1);
   localparam int PHASE_W = 3;

   localparam logic [7:0] SINK_TOP = 8'h80;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_SHIFT   = 2'd1,
      CMD_REFRESH = 2'd2,
      CMD_BLANK   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DRAIN,
      ST_REFRESH,
      ST_SINK,
      ST_BLANK
   } state_type;

   // buffer access request from the sequencer
   typedef struct packed {
      logic             rd_en;
      logic [POS_W-1:0] rd_addr;
      logic             wr_en;
      logic             wr_shift;   // write data comes from the last read
      logic [POS_W-1:0] wr_addr;
      logic [7:0]       wr_data;
   } buf_ctrl_type;

   // one queued output byte
   typedef struct packed {
      logic       use_mem;
      logic [7:0] byte_val;
      logic       is_sink;
      logic       last;
   } fetch_type;

endpackage

[design/led_matrix_scroll_scanner.sv]
// Top level of the LED matrix scroll scanner: fetch slot and output register.
// Depends on lmss_pkg, lmss_buffer and lmss_sequencer.
//
// Usage:
//   Requests arrive on req_* (valid/ready). Each carries a command: write one
//   column entry, shift the picture left by one column, refresh one scan phase,
//   or blank. Bytes for the LED shift chain leave on rsp_* (valid/ready);
//   rsp_last marks the final byte of a request, rsp_is_sink the sink select byte.
//   Per command:
//   - write: no bytes.
//   - shift: one entry per cycle through the single buffer read and write ports.
//   - refresh: MODULES + 1 bytes (11), one per cycle from the shared position
//     adder while the receiver keeps up, via the fetch slot and output register.
//   - blank: one zero byte.
//   A new request is taken once the sequencer is idle and its last byte has
//   left the fetch slot. On a receiver stall the output register holds, the
//   fetch slot fills, and the sequencer pauses in place.
//   Reset clears the buffer (valid bits), the scan phase and all handshakes.
module led_matrix_scroll_scanner (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [5:0] req_index,
   input  logic [7:0] req_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_sink,
   output logic       rsp_last
);

   lmss_pkg::buf_ctrl_type ctrl;
   lmss_pkg::fetch_type    fetch;
   lmss_pkg::fetch_type    fe_ff;
   logic                   issue;
   logic [7:0]             rd_byte;

   logic       fe_valid_ff, fe_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_sink_ff;
   logic       rsp_last_ff;
   logic       load;
   logic       can_issue;

   lmss_buffer u_buffer (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .rd_byte (rd_byte)
   );

   lmss_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_index (req_index),
      .req_value (req_value),
      .fe_idle   (!fe_valid_ff),
      .can_issue (can_issue),
      .req_ready (req_ready),
      .ctrl      (ctrl),
      .issue     (issue),
      .fetch     (fetch)
   );

   // fetch slot moves to the output register whenever that register frees up
   assign load      = fe_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign can_issue = !fe_valid_ff || load;

   always_comb begin
      fe_valid_in = fe_valid_ff;
      if (issue) begin
         fe_valid_in = 1'b1;
      end else if (load) begin
         fe_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fe_valid_ff  <= fe_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         fe_ff <= fetch;
      end
      if (load) begin
         // buffer read data is held until the slot drains
         rsp_byte_ff <= fe_ff.use_mem ? rd_byte : fe_ff.byte_val;
         rsp_sink_ff <= fe_ff.is_sink;
         rsp_last_ff <= fe_ff.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_is_sink  = rsp_sink_ff;
   assign rsp_last     = rsp_last_ff;

   a_req_only_when_drained: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !fe_valid_ff)
      else $error("request accepted with a byte still in the fetch slot");

   a_sink_last_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_sink |-> rsp_last)
      else $error("sink byte leaves without last");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !load)
      else $error("output register overwritten while stalled");

endmodule

[design/lmss_buffer.sv]
// Column buffer: one write and one registered read per cycle, per-entry valid bits.
// Depends on lmss_pkg.
module lmss_buffer (
   input  logic                 clock,
   input  logic                 reset,
   input  lmss_pkg::buf_ctrl_type ctrl,
   output logic [7:0]           rd_byte
);

   logic [7:0] mem [lmss_pkg::BUFFER_DEPTH];
   logic [lmss_pkg::BUFFER_DEPTH-1:0] valid_ff;
   logic [7:0] rd_data_ff;
   logic       rd_ok_ff;
   logic       rd_ok_in;
   logic [7:0] wr_value;
   logic [lmss_pkg::ADDR_W-1:0] rd_idx;
   logic [lmss_pkg::ADDR_W-1:0] wr_idx;

   assign rd_idx   = ctrl.rd_addr[lmss_pkg::ADDR_W-1:0];
   assign wr_idx   = ctrl.wr_addr[lmss_pkg::ADDR_W-1:0];
   assign rd_ok_in = ({1'b0, ctrl.rd_addr} < lmss_pkg::CMP_W'(lmss_pkg::BUFFER_DEPTH))
                     && valid_ff[rd_idx];
   // never-written or out-of-range entries read as zero
   assign rd_byte  = rd_ok_ff ? rd_data_ff : 8'h00;
   assign wr_value = ctrl.wr_shift ? rd_byte : ctrl.wr_data;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_idx] <= wr_value;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_idx];
         rd_ok_ff   <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

endmodule

[design/lmss_sequencer.sv]
// Command sequencer: steps one shared position adder through shift sweeps and refreshes.
// Depends on lmss_pkg.
module lmss_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_cmd,
   input  logic [5:0]             req_index,
   input  logic [7:0]             req_value,
   input  logic                   fe_idle,
   input  logic                   can_issue,
   output logic                   req_ready,
   output lmss_pkg::buf_ctrl_type ctrl,
   output logic                   issue,
   output lmss_pkg::fetch_type    fetch
);

   lmss_pkg::state_type state_ff, state_in;
   logic [lmss_pkg::POS_W-1:0]   p_ff, p_in;
   logic [lmss_pkg::MOD_W-1:0]   m_ff, m_in;
   logic [lmss_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic                         wr_pend_ff, wr_pend_in;
   logic [lmss_pkg::POS_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [lmss_pkg::POS_W-1:0]   step;
   logic [lmss_pkg::POS_W-1:0]   sum;
   logic [lmss_pkg::PHASE_W-1:0] phase_next;

   // the one shared adder: +1 while sweeping, +columns while scanning modules
   assign step = (state_ff == lmss_pkg::ST_SHIFT) ? lmss_pkg::POS_W'(1)
                 : lmss_pkg::POS_W'(lmss_pkg::COLUMNS_PER_MODULE);
   assign sum  = p_ff + step;
   assign phase_next = phase_ff + lmss_pkg::PHASE_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lmss_pkg::ST_IDLE;
         phase_ff   <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      m_ff       <= m_in;
      wr_addr_ff <= wr_addr_in;
   end

   always_comb begin
      state_in   = state_ff;
      p_in       = p_ff;
      m_in       = m_ff;
      phase_in   = phase_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      req_ready  = 1'b0;
      issue      = 1'b0;
      fetch      = '0;
      ctrl       = '0;

      // trailing write of the shift sweep
      if (wr_pend_ff) begin
         ctrl.wr_en    = 1'b1;
         ctrl.wr_shift = 1'b1;
         ctrl.wr_addr  = wr_addr_ff;
      end

      case (state_ff)
         lmss_pkg::ST_IDLE: begin
            req_ready = fe_idle;
            if (req_valid && fe_idle) begin
               case (lmss_pkg::cmd_type'(req_cmd))
                  lmss_pkg::CMD_WRITE: begin
                     if ({3'b000, req_index} <
                         lmss_pkg::CMP_W'(lmss_pkg::BUFFER_DEPTH)) begin
                        ctrl.wr_en   = 1'b1;
                        ctrl.wr_addr = lmss_pkg::POS_W'(req_index);
                        ctrl.wr_data = req_value;
                     end
                  end
                  lmss_pkg::CMD_SHIFT: begin
                     p_in     = '0;
                     phase_in = '0;
                     state_in = lmss_pkg::ST_SHIFT;
                  end
                  lmss_pkg::CMD_REFRESH: begin
                     p_in     = lmss_pkg::POS_W'(phase_ff);
                     m_in     = '0;
                     state_in = lmss_pkg::ST_REFRESH;
                  end
                  lmss_pkg::CMD_BLANK: begin
                     state_in = lmss_pkg::ST_BLANK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         lmss_pkg::ST_SHIFT: begin
            // read entry p+1 now, write it to entry p next cycle
            ctrl.rd_en   = 1'b1;
            ctrl.rd_addr = sum;
            p_in         = sum;
            wr_pend_in   = 1'b1;
            wr_addr_in   = p_ff;
            if ({1'b0, sum} == lmss_pkg::CMP_W'(lmss_pkg::BUFFER_DEPTH - 1)) begin
               state_in = lmss_pkg::ST_DRAIN;
            end
         end
         lmss_pkg::ST_DRAIN: begin
            state_in = lmss_pkg::ST_IDLE;
         end
         lmss_pkg::ST_REFRESH: begin
            if (can_issue) begin
               ctrl.rd_en    = 1'b1;
               ctrl.rd_addr  = p_ff;
               issue         = 1'b1;
               fetch.use_mem = 1'b1;
               p_in          = sum;
               m_in          = m_ff + lmss_pkg::MOD_W'(1);
               if (m_ff == lmss_pkg::MOD_W'(lmss_pkg::MODULES - 1)) begin
                  state_in = lmss_pkg::ST_SINK;
               end
            end
         end
         lmss_pkg::ST_SINK: begin
            if (can_issue) begin
               issue          = 1'b1;
               fetch.byte_val = lmss_pkg::SINK_TOP >> phase_ff;
               fetch.is_sink  = 1'b1;
               fetch.last     = 1'b1;
               if (phase_next >= lmss_pkg::PHASE_W'(lmss_pkg::COLUMNS_PER_MODULE)) begin
                  phase_in = '0;
               end else begin
                  phase_in = phase_next;
               end
               state_in = lmss_pkg::ST_IDLE;
            end
         end
         lmss_pkg::ST_BLANK: begin
            if (can_issue) begin
               issue      = 1'b1;
               fetch.last = 1'b1;
               state_in   = lmss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lmss_pkg::ST_IDLE;
         end
      endcase
   end

   a_issue_has_room: assert property (@(posedge clock) disable iff (reset)
      issue |-> can_issue)
      else $error("byte issued while fetch slot is occupied");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff < lmss_pkg::PHASE_W'(lmss_pkg::COLUMNS_PER_MODULE))
      else $error("scan phase out of range");

   a_sink_is_last: assert property (@(posedge clock) disable iff (reset)
      issue && fetch.is_sink |-> fetch.last)
      else $error("sink byte not marked last");

   a_shift_write_follows_read: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> $past(ctrl.rd_en))
      else $error("shift write without a preceding read");

endmodule
